[hw/rtl/nfst_pkg.sv]
// Shared types, codes and sizes of the next-fit slot table.
package nfst_pkg;

    localparam int CAPACITY    = 16;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH       = 3'd0,
        OP_WRITE      = 3'd1,
        OP_SET_STATE  = 3'd2,
        OP_LIST_OCC   = 3'd3,
        OP_LIST_STATE = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NO_MATCH = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_PUSH,
        CMD_WRITE,
        CMD_SET_STATE,
        CMD_RANGE,
        CMD_LIST_OCC,
        CMD_LIST_STATE
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_LIST
    } back_state_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [5:0]         slot_index;
        logic signed [31:0] entry_value;
        logic [7:0]         entry_state;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [3:0]         result_index;
        logic signed [31:0] result_value;
        logic [7:0]         result_state;
        logic               last;
    } rsp_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [SLOT_W-1:0]  index;
        logic signed [31:0] value;
        logic [7:0]         state;
    } cmd_t;

endpackage

[hw/rtl/nfst_front.sv]
// Front stage: accepts request beats, drops unknown opcodes and classifies the rest.
module nfst_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  nfst_pkg::req_t req,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output nfst_pkg::cmd_t cmd
);

    logic           cmd_valid_reg;
    logic           cmd_valid_next;
    nfst_pkg::cmd_t cmd_reg;
    nfst_pkg::cmd_t cmd_next;
    logic           accept;
    logic           known;
    logic           in_range;

    assign req_stall = cmd_valid_reg && !cmd_ready;
    assign accept    = req_valid && !req_stall;
    assign in_range  = ({1'b0, req.slot_index} < 7'(nfst_pkg::CAPACITY));

    always_comb
    begin
        known          = 1'b1;
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg && !cmd_ready;
        cmd_next.index = req.slot_index[nfst_pkg::SLOT_W-1:0];
        cmd_next.value = req.entry_value;
        cmd_next.state = req.entry_state;
        unique case (req.opcode)
            nfst_pkg::OP_PUSH:       cmd_next.kind = nfst_pkg::CMD_PUSH;
            nfst_pkg::OP_WRITE:
                cmd_next.kind = in_range ? nfst_pkg::CMD_WRITE : nfst_pkg::CMD_RANGE;
            nfst_pkg::OP_SET_STATE:
                cmd_next.kind = in_range ? nfst_pkg::CMD_SET_STATE : nfst_pkg::CMD_RANGE;
            nfst_pkg::OP_LIST_OCC:   cmd_next.kind = nfst_pkg::CMD_LIST_OCC;
            nfst_pkg::OP_LIST_STATE: cmd_next.kind = nfst_pkg::CMD_LIST_STATE;
            default:
            begin
                known         = 1'b0;
                cmd_next.kind = nfst_pkg::CMD_PUSH;
            end
        endcase
        if (accept && known)
        begin
            cmd_valid_next = 1'b1;
        end
        else
        begin
            cmd_next = cmd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

[hw/rtl/nfst_queue.sv]
// Short command queue between the front and back stages.
module nfst_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  nfst_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop,
    output nfst_pkg::cmd_t pop_cmd
);

    nfst_pkg::cmd_t                   mem_reg [nfst_pkg::QUEUE_DEPTH];
    logic [nfst_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [nfst_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [nfst_pkg::QCNT_W-1:0]      count_reg;
    logic [nfst_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [nfst_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [nfst_pkg::QCNT_W-1:0]      count_next;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = (count_reg != nfst_pkg::QCNT_W'(nfst_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == nfst_pkg::QPTR_W'(nfst_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == nfst_pkg::QPTR_W'(nfst_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/nfst_back.sv]
// Back stage: slot stores, next-fit search, listing sequencer and response register.
module nfst_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    input  nfst_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output nfst_pkg::rsp_t rsp
);

    localparam int CAP = nfst_pkg::CAPACITY;
    localparam int SW  = nfst_pkg::SLOT_W;

    logic signed [31:0]     value_store [CAP];
    logic [7:0]             state_store_reg [CAP];

    nfst_pkg::back_state_t  state_reg;
    nfst_pkg::back_state_t  state_next;
    logic [CAP-1:0]         rem_reg;
    logic [CAP-1:0]         rem_next;
    logic [SW-1:0]          head_reg;
    logic [SW-1:0]          head_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    nfst_pkg::rsp_t         rsp_reg;
    nfst_pkg::rsp_t         rsp_next;

    logic [CAP-1:0]         occupied;
    logic [CAP-1:0]         state_hit;
    logic [CAP-1:0]         above_head;
    logic [CAP-1:0]         free_all;
    logic [CAP-1:0]         free_hi;
    logic                   out_ok;
    logic [SW-1:0]          pick;
    logic                   st_we;
    logic                   val_we;
    logic [SW-1:0]          we_index;
    logic signed [31:0]     we_value;
    logic [7:0]             we_state;

    function automatic logic [SW-1:0] lowest_set(input logic [CAP-1:0] bits);
        logic [SW-1:0] pos;
        pos = '0;
        for (int i = CAP - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                pos = SW'(i);
            end
        end
        return pos;
    endfunction

    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            occupied[i]   = (state_store_reg[i] != 8'd0);
            state_hit[i]  = (state_store_reg[i] == cmd.state);
            above_head[i] = (SW'(i) >= head_reg);
        end
    end

    assign free_all = ~occupied;
    assign free_hi  = free_all & above_head;
    assign out_ok   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        head_next      = head_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        cmd_pop        = 1'b0;
        st_we          = 1'b0;
        val_we         = 1'b0;
        we_index       = cmd.index;
        we_value       = cmd.value;
        we_state       = cmd.state;
        pick           = '0;
        unique case (state_reg)
            nfst_pkg::BK_IDLE:
            begin
                if (cmd_valid && out_ok)
                begin
                    cmd_pop               = 1'b1;
                    rsp_next.status       = nfst_pkg::ST_OK;
                    rsp_next.result_index = 4'(cmd.index);
                    rsp_next.result_value = cmd.value;
                    rsp_next.result_state = cmd.state;
                    rsp_next.last         = 1'b1;
                    unique case (cmd.kind)
                        nfst_pkg::CMD_PUSH:
                        begin
                            rsp_valid_next = 1'b1;
                            if (free_all != '0)
                            begin
                                pick = (free_hi != '0) ? lowest_set(free_hi)
                                                       : lowest_set(free_all);
                                st_we                 = 1'b1;
                                val_we                = 1'b1;
                                we_index              = pick;
                                head_next             = (pick == SW'(CAP - 1))
                                                        ? '0 : pick + 1'b1;
                                rsp_next.result_index = 4'(pick);
                            end
                            else
                            begin
                                rsp_next.status       = nfst_pkg::ST_FULL;
                                rsp_next.result_index = 4'(head_reg);
                                rsp_next.result_value = '0;
                                rsp_next.result_state = '0;
                            end
                        end
                        nfst_pkg::CMD_WRITE:
                        begin
                            rsp_valid_next = 1'b1;
                            st_we          = 1'b1;
                            val_we         = 1'b1;
                        end
                        nfst_pkg::CMD_SET_STATE:
                        begin
                            rsp_valid_next        = 1'b1;
                            st_we                 = 1'b1;
                            rsp_next.result_value = value_store[cmd.index];
                        end
                        nfst_pkg::CMD_RANGE:
                        begin
                            rsp_valid_next        = 1'b1;
                            rsp_next.status       = nfst_pkg::ST_RANGE;
                            rsp_next.result_value = '0;
                            rsp_next.result_state = '0;
                        end
                        nfst_pkg::CMD_LIST_OCC:
                        begin
                            rsp_next   = rsp_reg;
                            rem_next   = occupied;
                            state_next = nfst_pkg::BK_LIST;
                        end
                        nfst_pkg::CMD_LIST_STATE:
                        begin
                            rsp_next   = rsp_reg;
                            rem_next   = state_hit;
                            state_next = nfst_pkg::BK_LIST;
                        end
                        default:
                        begin
                            rsp_next = rsp_reg;
                        end
                    endcase
                end
            end
            nfst_pkg::BK_LIST:
            begin
                if (out_ok)
                begin
                    rsp_valid_next = 1'b1;
                    if (rem_reg == '0)
                    begin
                        rsp_next.status       = nfst_pkg::ST_NO_MATCH;
                        rsp_next.result_index = '0;
                        rsp_next.result_value = '0;
                        rsp_next.result_state = '0;
                        rsp_next.last         = 1'b1;
                        state_next            = nfst_pkg::BK_IDLE;
                    end
                    else
                    begin
                        pick                  = lowest_set(rem_reg);
                        rem_next              = rem_reg & ~(CAP'(1) << pick);
                        rsp_next.status       = nfst_pkg::ST_OK;
                        rsp_next.result_index = 4'(pick);
                        rsp_next.result_value = value_store[pick];
                        rsp_next.result_state = state_store_reg[pick];
                        rsp_next.last         = (rem_next == '0);
                        if (rem_next == '0)
                        begin
                            state_next = nfst_pkg::BK_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = nfst_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfst_pkg::BK_IDLE;
            head_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < CAP; i++)
            begin
                state_store_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
            if (st_we)
            begin
                state_store_reg[we_index] <= we_state;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        rsp_reg <= rsp_next;
        if (val_we)
        begin
            value_store[we_index] <= we_value;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[hw/rtl/next_fit_slot_table_unit.sv]
// Top level of the next-fit slot table: front stage, command queue and back stage.
//
//  Channel   Signals                   Beat type         Direction
//  request   req_valid, req_stall, req nfst_pkg::req_t   into the block
//  response  rsp_valid, rsp_stall, rsp nfst_pkg::rsp_t   out of the block
//
// Push, write and set-state beats pass the back stage at one per cycle while rsp_stall is low.
// A list command first captures its match mask, then returns one response beat per matching slot
// (a single ST_NO_MATCH beat when nothing matches).
// Reset clears every slot state, the search head and all valid flags; no clearing pass is needed.
// Request and response stalls are decoupled by the front register and the two-entry queue.
module next_fit_slot_table_unit
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  nfst_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output nfst_pkg::rsp_t rsp
);

    logic           f_valid;
    logic           f_ready;
    nfst_pkg::cmd_t f_cmd;
    logic           q_valid;
    logic           q_pop;
    nfst_pkg::cmd_t q_cmd;

    nfst_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    nfst_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    nfst_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .cmd       (q_cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
